// File: src/rct_pkg.sv
// Shared constants, lookup table and interface types for the rumble command translator.
package rct_pkg;

    // Pipeline layout: decode stage, gain stages, then the per-side scaling lanes.
    localparam int DIV_STEPS   = 7;
    localparam int GAIN_STAGES = DIV_STEPS + 1;
    localparam int LANE_STAGES = 5;
    localparam int LANE_FIRST  = 1 + GAIN_STAGES;
    localparam int NUM_STAGES  = LANE_FIRST + LANE_STAGES;

    localparam logic [9:0] LOW_FREQ_MIN   = 10'h0b8;
    localparam logic [9:0] LOW_FREQ_MAX   = 10'h122;
    localparam logic [9:0] HIGH_FREQ_MIN  = 10'h160;
    localparam logic [9:0] HIGH_FREQ_MAX  = 10'h1f0;
    localparam logic [9:0] LOW_FREQ_IDLE  = 10'h0e1;
    localparam logic [9:0] HIGH_FREQ_IDLE = 10'h1e1;
    localparam logic [6:0] LOW_SPAN       = 7'(LOW_FREQ_MAX - LOW_FREQ_MIN);
    localparam logic [7:0] HIGH_SPAN      = 8'(HIGH_FREQ_MAX - HIGH_FREQ_MIN);

    localparam logic [39:0] IDLE_PAYLOAD = {10'd0, HIGH_FREQ_IDLE, 10'd0, LOW_FREQ_IDLE};

    localparam logic [6:0]  BAND_MAX     = 7'd100;
    localparam logic [7:0]  LO_BAND_BASE = 8'h40;
    localparam logic [6:0]  GAIN_FULL    = 7'd100;
    localparam logic [9:0]  AMP_RESET    = 10'd1023;
    localparam logic [14:0] PCT_ROUND    = 15'd50;
    localparam logic [6:0]  BYTE_ROUND   = 7'd127;

    // Reciprocals used in place of dividers: x / 100 for x < 2^15, x / 255 for x < 2^18.
    localparam logic [12:0] PCT_RECIP  = 13'd5243;
    localparam int          PCT_SHIFT  = 19;
    localparam logic [18:0] BYTE_RECIP = 19'd263173;
    localparam int          BYTE_SHIFT = 26;

    localparam int LEVEL_FULL = 255;
    localparam int PCT_DIV    = 100;

    typedef logic [100:0][7:0] level_lut_t;

    function automatic level_lut_t build_level_lut();
        level_lut_t lut;
        for (int i = 0; i <= 100; i++)
        begin
            lut[i] = 8'((i * LEVEL_FULL + PCT_DIV / 2) / PCT_DIV);
        end
        return lut;
    endfunction

    // Band index (0..100) to level (0..255), rounded.
    localparam level_lut_t LEVEL_LUT = build_level_lut();

    typedef struct packed {
        logic [15:0] dur;
        logic        active;
        logic [7:0]  light_lvl;
        logic [7:0]  heavy_lvl;
        logic [6:0]  lgain;
        logic [6:0]  rgain;
    } side_t;

    typedef struct packed {
        logic [8:0] left_sum;
        logic [8:0] right_sum;
        logic       hd_active;
    } gain_in_t;

    typedef struct packed {
        logic [6:0] lgain;
        logic [6:0] rgain;
    } gain_out_t;

endpackage

// File: src/rct_decode.sv
// One side's HD rumble word decoded into weak and strong levels.
module rct_decode (
    input  logic [31:0] hd_word,
    output logic [7:0]  weak_level,
    output logic [7:0]  strong_level
);
    import rct_pkg::*;

    logic [6:0] hi_idx;
    logic [6:0] hi_clamp;
    logic [7:0] lo_off;
    logic [8:0] lo_idx;
    logic [6:0] lo_clamp;

    always_comb
    begin
        hi_idx = hd_word[15:9];
        lo_off = hd_word[31:24] - LO_BAND_BASE;
        // The low band index is twice the byte offset, with bit 7 of byte 2 as the half step.
        if (hd_word[31:24] >= LO_BAND_BASE)
        begin
            lo_idx = {lo_off, hd_word[23]};
        end
        else
        begin
            lo_idx = '0;
        end
        hi_clamp = (hi_idx > BAND_MAX) ? BAND_MAX : hi_idx;
        lo_clamp = (lo_idx > 9'(BAND_MAX)) ? BAND_MAX : lo_idx[6:0];
    end

    assign weak_level   = LEVEL_LUT[hi_clamp];
    assign strong_level = LEVEL_LUT[lo_clamp];

endmodule

// File: src/rct_gain.sv
// Balance gain merge: a pipelined restoring divider giving the weaker side's percentage.
module rct_gain (
    input  logic                              clk,
    input  logic [rct_pkg::GAIN_STAGES-1:0]   stage_en,
    input  rct_pkg::gain_in_t                 gain_in,
    output rct_pkg::gain_out_t                gain_out
);
    import rct_pkg::*;

    typedef struct packed {
        logic [15:0] rem;
        logic [8:0]  peak;
        logic [6:0]  quot;
        logic        left_big;
        logic        hd_active;
    } div_stage_t;

    div_stage_t div_reg  [GAIN_STAGES];
    div_stage_t div_next [GAIN_STAGES];

    logic [8:0] small_energy;

    // The stronger side always gets the full gain, so only the weaker side is divided.
    always_comb
    begin
        div_next[0].left_big  = (gain_in.left_sum >= gain_in.right_sum);
        div_next[0].hd_active = gain_in.hd_active;
        div_next[0].peak      = div_next[0].left_big ? gain_in.left_sum
                                                     : gain_in.right_sum;
        small_energy          = div_next[0].left_big ? gain_in.right_sum
                                                     : gain_in.left_sum;
        div_next[0].rem       = 16'(small_energy) * 16'(GAIN_FULL)
                              + 16'(div_next[0].peak >> 1);
        div_next[0].quot      = '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [15:0] trial;

        assign trial = 16'(div_reg[k].peak) << (DIV_STEPS - 1 - k);

        always_comb
        begin
            div_next[k+1] = div_reg[k];
            if (div_reg[k].rem >= trial)
            begin
                div_next[k+1].rem                   = div_reg[k].rem - trial;
                div_next[k+1].quot[DIV_STEPS-1-k]   = 1'b1;
            end
        end
    end

    for (genvar s = 0; s < GAIN_STAGES; s++)
    begin : g_reg
        always_ff @(posedge clk)
        begin
            if (stage_en[s])
            begin
                div_reg[s] <= div_next[s];
            end
        end
    end

    always_comb
    begin
        gain_out.lgain = GAIN_FULL;
        gain_out.rgain = GAIN_FULL;
        if (div_reg[GAIN_STAGES-1].hd_active)
        begin
            if (div_reg[GAIN_STAGES-1].left_big)
            begin
                gain_out.rgain = div_reg[GAIN_STAGES-1].quot;
            end
            else
            begin
                gain_out.lgain = div_reg[GAIN_STAGES-1].quot;
            end
        end
    end

endmodule

// File: src/rct_lane.sv
// One side's scaling lane: gain, amplitude scaling, frequency mix and payload packing.
module rct_lane (
    input  logic                              clk,
    input  logic [rct_pkg::LANE_STAGES-1:0]   stage_en,
    input  logic [7:0]                        weak_level,
    input  logic [7:0]                        strong_level,
    input  logic [6:0]                        gain,
    input  logic [9:0]                        max_amp,
    output logic [39:0]                       payload
);
    import rct_pkg::*;

    function automatic logic [7:0] div_by_100(input logic [14:0] x);
        logic [27:0] prod;
        prod = 28'(x) * 28'(PCT_RECIP);
        return 8'(prod >> PCT_SHIFT);
    endfunction

    function automatic logic [9:0] div_by_255(input logic [17:0] x);
        logic [36:0] prod;
        prod = 37'(x) * 37'(BYTE_RECIP);
        return 10'(prod >> BYTE_SHIFT);
    endfunction

    logic [14:0] wprod_reg, sprod_reg;
    logic [7:0]  wscl_reg, sscl_reg;
    logic [17:0] hamp_prod_reg, lamp_prod_reg;
    logic [15:0] hmix_prod_reg;
    logic [14:0] lmix_prod_reg;
    logic [9:0]  hamp_reg, lamp_reg;
    logic [7:0]  hmix_reg;
    logic [6:0]  lmix_reg;
    logic [39:0] payload_reg;

    logic [14:0] wprod_next, sprod_next;
    logic [17:0] hamp_prod_next, lamp_prod_next;
    logic [15:0] hmix_prod_next;
    logic [14:0] lmix_prod_next;
    logic [9:0]  lfreq, hfreq;
    logic [39:0] payload_next;

    always_comb
    begin
        wprod_next     = 15'(weak_level) * 15'(gain) + PCT_ROUND;
        sprod_next     = 15'(strong_level) * 15'(gain) + PCT_ROUND;
        hamp_prod_next = 18'(wscl_reg) * 18'(max_amp) + 18'(BYTE_ROUND);
        lamp_prod_next = 18'(sscl_reg) * 18'(max_amp) + 18'(BYTE_ROUND);
        hmix_prod_next = 16'(wscl_reg) * 16'(HIGH_SPAN) + 16'(BYTE_ROUND);
        lmix_prod_next = 15'(sscl_reg) * 15'(LOW_SPAN) + 15'(BYTE_ROUND);
        // A band with no amplitude sits at its idle frequency.
        lfreq = (lamp_reg != '0) ? LOW_FREQ_MIN + 10'(lmix_reg) : LOW_FREQ_IDLE;
        hfreq = (hamp_reg != '0) ? HIGH_FREQ_MIN + 10'(hmix_reg) : HIGH_FREQ_IDLE;
        payload_next = {hamp_reg, hfreq, lamp_reg, lfreq};
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            wprod_reg <= wprod_next;
            sprod_reg <= sprod_next;
        end
        if (stage_en[1])
        begin
            wscl_reg <= div_by_100(wprod_reg);
            sscl_reg <= div_by_100(sprod_reg);
        end
        if (stage_en[2])
        begin
            hamp_prod_reg <= hamp_prod_next;
            lamp_prod_reg <= lamp_prod_next;
            hmix_prod_reg <= hmix_prod_next;
            lmix_prod_reg <= lmix_prod_next;
        end
        if (stage_en[3])
        begin
            hamp_reg <= div_by_255(hamp_prod_reg);
            lamp_reg <= div_by_255(lamp_prod_reg);
            hmix_reg <= 8'(div_by_255(18'(hmix_prod_reg)));
            lmix_reg <= 7'(div_by_255(18'(lmix_prod_reg)));
        end
        if (stage_en[4])
        begin
            payload_reg <= payload_next;
        end
    end

    assign payload = payload_reg;

endmodule

// File: src/rumble_command_translator_top.sv
// Top level of the rumble command translator.
//
// A command enters on the cmd channel (cmd_valid / cmd_stall) and carries either two
// motor levels (req_type 0) or two HD rumble words (req_type 1). Each command gives one
// transaction on the rsp channel (rsp_valid / rsp_stall): left and right 40-bit payloads,
// the active flag, both balance gains and the duration copied through.
// The block is a 14-stage pipeline: decode of both sides in two lanes, a 7-step restoring
// divider for the balance gain, then two identical scaling lanes. One command is taken
// every cycle while cmd_stall is low.
// While rsp_stall is high the held result stays unchanged and the stages behind it keep
// filling until every stage is occupied; only then is cmd_stall raised.
// Reset empties the pipeline and sets the full-scale amplitude to 1023; cfg_wr_en writes a
// new value from cfg_wr_data at the next edge and is meant for times when no command is in
// flight.
module rumble_command_translator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic        req_type,
    input  logic [7:0]  light_motor,
    input  logic [7:0]  heavy_motor,
    input  logic [31:0] left_hd_word,
    input  logic [31:0] right_hd_word,
    input  logic [15:0] duration,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [39:0] left_payload,
    output logic [39:0] right_payload,
    output logic        active_flag,
    output logic [6:0]  left_pct,
    output logic [6:0]  right_pct,
    output logic [15:0] duration_out,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data
);
    import rct_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg, vld_next, stage_rdy;
    logic [9:0]            max_amp_reg;

    side_t     side_reg  [NUM_STAGES];
    side_t     side_next [NUM_STAGES];
    gain_in_t  gain_in_reg, gain_in_next;
    gain_out_t gain_out;

    logic [7:0] lw_level, ls_level, rw_level, rs_level;

    // A stage may load when any stage from it onwards holds a bubble or the output drains.
    always_comb
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            stage_rdy[i] = !rsp_stall
                         || !(&(vld_reg | ((NUM_STAGES'(1) << i) - NUM_STAGES'(1))));
        end
        vld_next[0] = stage_rdy[0] ? cmd_valid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            vld_next[i] = stage_rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            max_amp_reg <= AMP_RESET;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_wr_en)
            begin
                max_amp_reg <= cfg_wr_data;
            end
        end
    end

    rct_decode u_decode_left (
        .hd_word      (left_hd_word),
        .weak_level   (lw_level),
        .strong_level (ls_level)
    );

    rct_decode u_decode_right (
        .hd_word      (right_hd_word),
        .weak_level   (rw_level),
        .strong_level (rs_level)
    );

    always_comb
    begin
        side_next[0].dur   = duration;
        side_next[0].lgain = GAIN_FULL;
        side_next[0].rgain = GAIN_FULL;
        if (req_type)
        begin
            side_next[0].light_lvl = (lw_level > rw_level) ? lw_level : rw_level;
            side_next[0].heavy_lvl = (ls_level > rs_level) ? ls_level : rs_level;
        end
        else
        begin
            side_next[0].light_lvl = light_motor;
            side_next[0].heavy_lvl = heavy_motor;
        end
        side_next[0].active = (side_next[0].light_lvl != '0)
                           || (side_next[0].heavy_lvl != '0);
        gain_in_next.left_sum  = 9'(lw_level) + 9'(ls_level);
        gain_in_next.right_sum = 9'(rw_level) + 9'(rs_level);
        gain_in_next.hd_active = req_type && side_next[0].active;
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            gain_in_reg <= gain_in_next;
        end
    end

    for (genvar i = 1; i < NUM_STAGES; i++)
    begin : g_side
        if (i == LANE_FIRST)
        begin : g_gain_load
            always_comb
            begin
                side_next[i]       = side_reg[i-1];
                side_next[i].lgain = gain_out.lgain;
                side_next[i].rgain = gain_out.rgain;
            end
        end
        else
        begin : g_pass
            assign side_next[i] = side_reg[i-1];
        end
    end

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_side_reg
        always_ff @(posedge clk)
        begin
            if (stage_rdy[i])
            begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    rct_gain u_gain (
        .clk      (clk),
        .stage_en (stage_rdy[GAIN_STAGES:1]),
        .gain_in  (gain_in_reg),
        .gain_out (gain_out)
    );

    rct_lane u_lane_left (
        .clk          (clk),
        .stage_en     (stage_rdy[NUM_STAGES-1:LANE_FIRST]),
        .weak_level   (side_reg[LANE_FIRST-1].light_lvl),
        .strong_level (side_reg[LANE_FIRST-1].heavy_lvl),
        .gain         (gain_out.lgain),
        .max_amp      (max_amp_reg),
        .payload      (left_payload)
    );

    rct_lane u_lane_right (
        .clk          (clk),
        .stage_en     (stage_rdy[NUM_STAGES-1:LANE_FIRST]),
        .weak_level   (side_reg[LANE_FIRST-1].light_lvl),
        .strong_level (side_reg[LANE_FIRST-1].heavy_lvl),
        .gain         (gain_out.rgain),
        .max_amp      (max_amp_reg),
        .payload      (right_payload)
    );

    assign cmd_stall    = !stage_rdy[0];
    assign rsp_valid    = vld_reg[NUM_STAGES-1];
    assign active_flag  = side_reg[NUM_STAGES-1].active;
    assign left_pct     = side_reg[NUM_STAGES-1].lgain;
    assign right_pct    = side_reg[NUM_STAGES-1].rgain;
    assign duration_out = side_reg[NUM_STAGES-1].dur;

endmodule

// File: src/rct_checker.sv
// Port-level checks on the rumble command translator, bound to its top level.
module rct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [39:0] left_payload,
    input logic [39:0] right_payload,
    input logic        active_flag,
    input logic [6:0]  left_pct,
    input logic [6:0]  right_pct,
    input logic [15:0] duration_out
);
    import rct_pkg::*;

    // A stalled result transaction holds until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(left_payload)
            && $stable(right_payload) && $stable(duration_out))
        else $error("result changed while stalled");

    // An inactive command gives the idle payload on both sides at full gain.
    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !active_flag |-> left_payload == IDLE_PAYLOAD
            && right_payload == IDLE_PAYLOAD && left_pct == GAIN_FULL
            && right_pct == GAIN_FULL)
        else $error("inactive result is not the idle payload");

    // The stronger side always keeps the full gain.
    a_full_side: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> left_pct == GAIN_FULL || right_pct == GAIN_FULL)
        else $error("neither side has full gain");

    // A silent band reports its idle frequency.
    a_silent_band: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |->
            (left_payload[19:10] != '0 || left_payload[9:0] == LOW_FREQ_IDLE)
            && (left_payload[39:30] != '0 || left_payload[29:20] == HIGH_FREQ_IDLE)
            && (right_payload[19:10] != '0 || right_payload[9:0] == LOW_FREQ_IDLE)
            && (right_payload[39:30] != '0 || right_payload[29:20] == HIGH_FREQ_IDLE))
        else $error("silent band has a non-idle frequency");

endmodule

bind rumble_command_translator_top rct_checker u_rct_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the rumble command translator with a built-in payload predictor.
`timescale 1ns / 100ps

module testbench;

    localparam logic REQ_MOTOR = 1'b0;
    localparam logic REQ_HD    = 1'b1;

    localparam int unsigned LF_LOW  = 'h0b8;
    localparam int unsigned LF_HIGH = 'h122;
    localparam int unsigned HF_LOW  = 'h160;
    localparam int unsigned HF_HIGH = 'h1f0;
    localparam int unsigned LF_REST = 'h0e1;
    localparam int unsigned HF_REST = 'h1e1;

    localparam int PHASES        = 8;
    localparam int CMDS_PER_PHASE = 125;
    localparam int QUIET_PHASE   = 3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  light;
        logic [7:0]  heavy;
        logic [31:0] left_word;
        logic [31:0] right_word;
        logic [15:0] dur_ms;
    } rumble_cmd_t;

    typedef struct packed {
        logic [39:0] left_pay;
        logic [39:0] right_pay;
        logic        active;
        logic [6:0]  lgain;
        logic [6:0]  rgain;
        logic [15:0] dur_ms;
    } rumble_out_t;

    typedef struct packed {
        rumble_cmd_t cmd;
        logic        typed;
        rumble_out_t want;
    } dir_row_t;

    localparam logic [39:0] IDLE_PAY = {10'd0, 10'h1e1, 10'd0, 10'h0e1};
    localparam logic [39:0] FULL_PAY = {10'd1023, 10'h1f0, 10'd1023, 10'h122};
    localparam rumble_out_t NO_WANT  = '0;

    // Rows with a typed result are only valid at the reset amplitude of 1023.
    localparam int DIR_ROWS = 18;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{REQ_MOTOR, 8'd0, 8'd0, 32'hffffffff, 32'hffffffff, 16'd0}, 1'b1,
          '{IDLE_PAY, IDLE_PAY, 1'b0, 7'd100, 7'd100, 16'd0}},
        '{'{REQ_MOTOR, 8'd255, 8'd255, 32'h0, 32'h0, 16'hffff}, 1'b1,
          '{FULL_PAY, FULL_PAY, 1'b1, 7'd100, 7'd100, 16'hffff}},
        '{'{REQ_MOTOR, 8'd255, 8'd0, 32'h0, 32'h0, 16'd1}, 1'b0, NO_WANT},
        '{'{REQ_MOTOR, 8'd0, 8'd255, 32'h0, 32'h0, 16'd2}, 1'b0, NO_WANT},
        '{'{REQ_MOTOR, 8'd1, 8'd1, 32'h12345678, 32'h9abcdef0, 16'h5555}, 1'b0, NO_WANT},
        '{'{REQ_MOTOR, 8'd128, 8'd64, 32'h0, 32'h0, 16'haaaa}, 1'b0, NO_WANT},
        '{'{REQ_MOTOR, 8'd0, 8'd1, 32'h0, 32'h0, 16'd7}, 1'b0, NO_WANT},
        '{'{REQ_MOTOR, 8'd1, 8'd0, 32'h0, 32'h0, 16'd8}, 1'b0, NO_WANT},
        '{'{REQ_HD, 8'd255, 8'd255, 32'h0, 32'h0, 16'h8000}, 1'b1,
          '{IDLE_PAY, IDLE_PAY, 1'b0, 7'd100, 7'd100, 16'h8000}},
        '{'{REQ_HD, 8'd0, 8'd0, 32'hffffffff, 32'hffffffff, 16'h0001}, 1'b1,
          '{FULL_PAY, FULL_PAY, 1'b1, 7'd100, 7'd100, 16'h0001}},
        // Low band below its base byte, and a high band byte with only the ignored bit set.
        '{'{REQ_HD, 8'd0, 8'd0, 32'h3fff0000, 32'h000001ff, 16'h00ff}, 1'b1,
          '{IDLE_PAY, IDLE_PAY, 1'b0, 7'd100, 7'd100, 16'h00ff}},
        '{'{REQ_HD, 8'd0, 8'd0, 32'h40000000, 32'h0, 16'h0100}, 1'b1,
          '{IDLE_PAY, IDLE_PAY, 1'b0, 7'd100, 7'd100, 16'h0100}},
        '{'{REQ_HD, 8'd0, 8'd0, 32'h40800000, 32'h0, 16'd3}, 1'b0, NO_WANT},
        // Left at exactly index 100 on both bands, right silent: the right gain drops to 0.
        '{'{REQ_HD, 8'd0, 8'd0, 32'h7200c800, 32'h0, 16'd4}, 1'b1,
          '{FULL_PAY, IDLE_PAY, 1'b1, 7'd100, 7'd0, 16'd4}},
        '{'{REQ_HD, 8'd0, 8'd0, 32'h0, 32'h72ffca01, 16'd5}, 1'b0, NO_WANT},
        '{'{REQ_HD, 8'd0, 8'd0, 32'h60001400, 32'h50003200, 16'd6}, 1'b0, NO_WANT},
        '{'{REQ_HD, 8'd0, 8'd0, 32'h41000200, 32'hff80ff00, 16'h7fff}, 1'b0, NO_WANT},
        '{'{REQ_HD, 8'd0, 8'd0, 32'hc0000000, 32'h00006400, 16'hfffe}, 1'b0, NO_WANT}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic        req_type = 1'b0;
    logic [7:0]  light_motor = '0;
    logic [7:0]  heavy_motor = '0;
    logic [31:0] left_hd_word = '0;
    logic [31:0] right_hd_word = '0;
    logic [15:0] duration = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [39:0] left_payload;
    logic [39:0] right_payload;
    logic        active_flag;
    logic [6:0]  left_pct;
    logic [6:0]  right_pct;
    logic [15:0] duration_out;
    logic        cfg_wr_en = 1'b0;
    logic [9:0]  cfg_wr_data = '0;

    rumble_out_t  rumble_expect_q [$];
    rumble_out_t  arrived_want;
    int unsigned  amp_setting = 1023;
    logic         no_gaps = 1'b0;
    int           n_errors = 0;
    int           n_sent = 0;
    int           n_hd = 0;
    int           n_checked = 0;
    int           n_active = 0;
    int           n_settings = 1;

    rumble_command_translator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .req_type      (req_type),
        .light_motor   (light_motor),
        .heavy_motor   (heavy_motor),
        .left_hd_word  (left_hd_word),
        .right_hd_word (right_hd_word),
        .duration      (duration),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .left_payload  (left_payload),
        .right_payload (right_payload),
        .active_flag   (active_flag),
        .left_pct      (left_pct),
        .right_pct     (right_pct),
        .duration_out  (duration_out),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned band_to_level(input int unsigned idx);
        int unsigned clamped;
        clamped = (idx > 100) ? 100 : idx;
        return (clamped * 255 + 50) / 100;
    endfunction

    function automatic void split_hd(input logic [31:0] w, output int unsigned light_lvl,
                                     output int unsigned heavy_lvl);
        int unsigned low_idx;
        low_idx = 0;
        if (w[31:24] >= 8'h40)
        begin
            low_idx = 2 * (32'(w[31:24]) - 32'h40) + 32'(w[23]);
        end
        light_lvl = band_to_level(32'(w[15:9]));
        heavy_lvl = band_to_level(low_idx);
    endfunction

    function automatic int unsigned percent_of(input int unsigned level, input int unsigned pct);
        return (level * pct + 50) / 100;
    endfunction

    function automatic logic [39:0] pack_lane(input int unsigned light_lvl,
                                              input int unsigned heavy_lvl,
                                              input int unsigned full);
        int unsigned lo_amp;
        int unsigned hi_amp;
        int unsigned lo_hz;
        int unsigned hi_hz;
        lo_amp = (heavy_lvl * full + 127) / 255;
        hi_amp = (light_lvl * full + 127) / 255;
        lo_hz  = LF_REST;
        hi_hz  = HF_REST;
        // A band whose amplitude rounds to zero keeps its resting frequency.
        if (lo_amp != 0)
        begin
            lo_hz = LF_LOW + ((LF_HIGH - LF_LOW) * heavy_lvl + 127) / 255;
        end
        if (hi_amp != 0)
        begin
            hi_hz = HF_LOW + ((HF_HIGH - HF_LOW) * light_lvl + 127) / 255;
        end
        return {10'(hi_amp), 10'(hi_hz), 10'(lo_amp), 10'(lo_hz)};
    endfunction

    function automatic rumble_out_t predict_rumble(input rumble_cmd_t c, input int unsigned full);
        rumble_out_t r;
        int unsigned light_lvl;
        int unsigned heavy_lvl;
        int unsigned lw;
        int unsigned ls;
        int unsigned rw;
        int unsigned rs;
        int unsigned le;
        int unsigned re;
        int unsigned peak;
        int unsigned lg;
        int unsigned rg;
        lg = 100;
        rg = 100;
        if (c.kind == REQ_MOTOR)
        begin
            light_lvl = c.light;
            heavy_lvl = c.heavy;
        end
        else
        begin
            split_hd(c.left_word, lw, ls);
            split_hd(c.right_word, rw, rs);
            light_lvl = (lw > rw) ? lw : rw;
            heavy_lvl = (ls > rs) ? ls : rs;
            if (light_lvl != 0 || heavy_lvl != 0)
            begin
                le   = lw + ls;
                re   = rw + rs;
                peak = (le > re) ? le : re;
                lg   = (le * 100 + peak / 2) / peak;
                rg   = (re * 100 + peak / 2) / peak;
            end
        end
        r.active = (light_lvl != 0 || heavy_lvl != 0);
        if (r.active)
        begin
            r.left_pay  = pack_lane(percent_of(light_lvl, lg), percent_of(heavy_lvl, lg), full);
            r.right_pay = pack_lane(percent_of(light_lvl, rg), percent_of(heavy_lvl, rg), full);
        end
        else
        begin
            r.left_pay  = pack_lane(0, 0, 0);
            r.right_pay = r.left_pay;
        end
        r.lgain  = 7'(lg);
        r.rgain  = 7'(rg);
        r.dur_ms = c.dur_ms;
        return r;
    endfunction

    // Fully random fields, then bent towards silent sides, near-threshold bands and so on.
    function automatic rumble_cmd_t random_cmd();
        rumble_cmd_t c;
        c.kind       = 1'($urandom_range(0, 1));
        c.light      = 8'($urandom);
        c.heavy      = 8'($urandom);
        c.left_word  = $urandom;
        c.right_word = $urandom;
        c.dur_ms     = 16'($urandom);
        case ($urandom_range(0, 9))
            0: c.light = '0;
            1: c.heavy = '0;
            2:
            begin
                c.light = 8'($urandom_range(0, 3));
                c.heavy = 8'($urandom_range(0, 3));
            end
            3: c.right_word = '0;
            4: c.left_word = '0;
            5: c.right_word = c.left_word;
            6:
            begin
                c.left_word[15:8]  = 8'($urandom_range(0, 3));
                c.left_word[31:24] = 8'($urandom_range(8'h3e, 8'h42));
            end
            7:
            begin
                c.left_word  &= 32'h3f7f01ff;
                c.right_word &= 32'h3f7f01ff;
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_cmd(input rumble_cmd_t c, input logic typed, input rumble_out_t want);
        while (!no_gaps && $urandom_range(0, 99) < 6)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid     <= 1'b1;
        req_type      <= c.kind;
        light_motor   <= c.light;
        heavy_motor   <= c.heavy;
        left_hd_word  <= c.left_word;
        right_hd_word <= c.right_word;
        duration      <= c.dur_ms;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        rumble_expect_q.push_back(typed ? want : predict_rumble(c, amp_setting));
        n_sent++;
        if (c.kind == REQ_HD)
        begin
            n_hd++;
        end
    endtask

    // The amplitude register is only changed once every transaction in flight has come out.
    task automatic write_amplitude(input int unsigned value);
        cmd_valid <= 1'b0;
        while (rumble_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 10'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        amp_setting = value;
        n_settings++;
    endtask

    always @(posedge clk)
    begin
        rsp_stall <= !no_gaps && ($urandom_range(0, 99) < 6);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            n_checked++;
            if (rumble_expect_q.size() == 0)
            begin
                $error("result transaction arrived with nothing expected");
                n_errors++;
            end
            else
            begin
                arrived_want = rumble_expect_q.pop_front();
                if (arrived_want.active)
                begin
                    n_active++;
                end
                if (left_payload !== arrived_want.left_pay)
                begin
                    $error("left_payload: expected %h, got %h", arrived_want.left_pay,
                           left_payload);
                    n_errors++;
                end
                if (right_payload !== arrived_want.right_pay)
                begin
                    $error("right_payload: expected %h, got %h", arrived_want.right_pay,
                           right_payload);
                    n_errors++;
                end
                if (active_flag !== arrived_want.active)
                begin
                    $error("active_flag: expected %b, got %b", arrived_want.active, active_flag);
                    n_errors++;
                end
                if (left_pct !== arrived_want.lgain)
                begin
                    $error("left_pct: expected %0d, got %0d", arrived_want.lgain, left_pct);
                    n_errors++;
                end
                if (right_pct !== arrived_want.rgain)
                begin
                    $error("right_pct: expected %0d, got %0d", arrived_want.rgain, right_pct);
                    n_errors++;
                end
                if (duration_out !== arrived_want.dur_ms)
                begin
                    $error("duration_out: expected %h, got %h", arrived_want.dur_ms,
                           duration_out);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        int unsigned amp_plan [PHASES];
        amp_plan = '{0, 1, 1023, 512, 0, 0, 2, 1022};
        amp_plan[4] = $urandom_range(0, 1023);
        amp_plan[5] = $urandom_range(0, 1023);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_cmd(DIR_TABLE[i].cmd, DIR_TABLE[i].typed, DIR_TABLE[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_amplitude(amp_plan[p]);
            no_gaps <= (p == QUIET_PHASE);
            for (int i = 0; i < CMDS_PER_PHASE; i++)
            begin
                send_cmd(random_cmd(), 1'b0, NO_WANT);
            end
        end

        cmd_valid <= 1'b0;
        while (rumble_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * rct_pkg::NUM_STAGES) @(posedge clk);

        $display("Sent %0d commands (%0d HD rumble, %0d motor level) under %0d amplitudes.",
                 n_sent, n_hd, n_sent - n_hd, n_settings);
        $display("Checked %0d result transactions, %0d of them active; %0d mismatches.",
                 n_checked, n_active, n_errors);
        if (n_errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Run timed out with %0d transactions still expected.", rumble_expect_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
src/rct_pkg.sv
src/rct_decode.sv
src/rct_gain.sv
src/rct_lane.sv
src/rumble_command_translator_top.sv
src/rct_checker.sv
tb/testbench.sv
